### hw/rtl/mmsc_pkg.sv
// Shared types and constants for the Manhattan minimum spanning cost block.
package mmsc_pkg;

    // Width of the reported tree cost; wider sums wrap to this width
    localparam int TOTAL_W = 25;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_we;      // write one point into the store
        logic rd_en;        // issue one store read into the sweep pipeline
        logic first;        // first sweep: best distances and tree flags start fresh
        logic pick_clear;   // restart the nearest-point search
        logic commit;       // join the picked point and add its link to the total
        logic total_clear;  // zero the running total
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic pipe_busy;    // sweep pipeline still holds entries
        logic pick_found;   // search has a candidate
    } t_dp_status;

endpackage

### hw/rtl/mmsc_dp.sv
// Datapath: point store, Prim sweep pipeline, nearest-point search and cost accumulator.
module mmsc_dp
    import mmsc_pkg::*;
#(
    parameter int MAX_POINTS = 256,
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_dp_cmd                      i_cmd,
    input  logic [$clog2(MAX_POINTS)-1:0] i_addr,
    input  logic signed [COORD_BITS-1:0] i_x,
    input  logic signed [COORD_BITS-1:0] i_y,
    output t_dp_status                   o_status,
    output logic [TOTAL_W-1:0]           o_total
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int MW = COORD_BITS + 1;   // magnitude of one coordinate difference
    localparam int DW = COORD_BITS + 2;   // Manhattan distance

    // Stores
    logic [COORD_BITS-1:0] r_mem_x    [MAX_POINTS];
    logic [COORD_BITS-1:0] r_mem_y    [MAX_POINTS];
    logic [DW-1:0]         r_mem_best [MAX_POINTS];
    logic                  r_mem_join [MAX_POINTS];

    // Current tree point (the one joined last)
    logic [COORD_BITS-1:0] r_cur_x, r_cur_y;

    // Read stage
    logic                  r_v1;
    logic [AW-1:0]         r_i1;
    logic [COORD_BITS-1:0] r_rd_x, r_rd_y;
    logic [DW-1:0]         r_rd_best;
    logic                  r_rd_join;

    // Difference stage
    logic                  r_v2;
    logic [AW-1:0]         r_i2;
    logic [COORD_BITS-1:0] r_x2, r_y2;
    logic [MW-1:0]         r_adx, r_ady;
    logic [DW-1:0]         r_b2;
    logic                  r_j2;

    // Update stage
    logic                  r_v3;
    logic [AW-1:0]         r_i3;
    logic [COORD_BITS-1:0] r_x3, r_y3;
    logic [DW-1:0]         r_d3;
    logic                  r_j3;

    // Search result and total
    logic                  r_found;
    logic [AW-1:0]         r_pick_i;
    logic [DW-1:0]         r_pick_d;
    logic [COORD_BITS-1:0] r_pick_x, r_pick_y;
    logic [TOTAL_W-1:0]    r_total;

    logic [MW-1:0]         dx_ab, dx_ba, dy_ab, dy_ba;
    logic [DW-1:0]         link_dist, new_best;
    logic                  join_now;
    logic                  join_we;
    logic [AW-1:0]         join_addr;
    logic                  join_val;

    // Point store: load writes, sweep reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we) begin
            r_mem_x[i_addr] <= i_x;
            r_mem_y[i_addr] <= i_y;
        end
        if (i_cmd.rd_en) begin
            r_rd_x <= r_mem_x[i_addr];
            r_rd_y <= r_mem_y[i_addr];
        end
    end

    // Best link distance store
    always_ff @(posedge i_clk) begin
        if (r_v2) begin
            r_mem_best[r_i2] <= new_best;
        end
        if (i_cmd.rd_en) begin
            r_rd_best <= r_mem_best[i_addr];
        end
    end

    // Tree membership store: set up on the first sweep, marked on each commit
    always_comb begin
        join_we   = 1'b0;
        join_addr = r_i2;
        join_val  = 1'b0;
        if (r_v2 && i_cmd.first) begin
            join_we  = 1'b1;
            join_val = (r_i2 == '0);
        end else if (i_cmd.commit) begin
            join_we   = 1'b1;
            join_addr = r_pick_i;
            join_val  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (join_we) begin
            r_mem_join[join_addr] <= join_val;
        end
        if (i_cmd.rd_en) begin
            r_rd_join <= r_mem_join[i_addr];
        end
    end

    // Coordinate differences both ways, sign picks the magnitude
    assign dx_ab = {r_rd_x[COORD_BITS-1], r_rd_x} - {r_cur_x[COORD_BITS-1], r_cur_x};
    assign dx_ba = {r_cur_x[COORD_BITS-1], r_cur_x} - {r_rd_x[COORD_BITS-1], r_rd_x};
    assign dy_ab = {r_rd_y[COORD_BITS-1], r_rd_y} - {r_cur_y[COORD_BITS-1], r_cur_y};
    assign dy_ba = {r_cur_y[COORD_BITS-1], r_cur_y} - {r_rd_y[COORD_BITS-1], r_rd_y};

    // Distance to the current point and relaxed best link
    assign link_dist = {1'b0, r_adx} + {1'b0, r_ady};
    assign new_best  = (i_cmd.first || (link_dist < r_b2)) ? link_dist : r_b2;
    assign join_now  = i_cmd.first ? (r_i1 == '0) : r_rd_join;

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        r_i1  <= i_addr;
        r_i2  <= r_i1;
        r_x2  <= r_rd_x;
        r_y2  <= r_rd_y;
        r_adx <= dx_ab[MW-1] ? dx_ba : dx_ab;
        r_ady <= dy_ab[MW-1] ? dy_ba : dy_ab;
        r_b2  <= r_rd_best;
        r_j2  <= join_now;
        r_i3  <= r_i2;
        r_x3  <= r_x2;
        r_y3  <= r_y2;
        r_d3  <= new_best;
        r_j3  <= r_j2;
    end

    // Pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.rd_en;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Nearest unjoined point; strict compare keeps the lowest index on ties
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_cmd.pick_clear) begin
            r_found <= 1'b0;
        end else if (r_v3 && !r_j3 && (!r_found || (r_d3 < r_pick_d))) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v3 && !r_j3 && (!r_found || (r_d3 < r_pick_d)) && !i_cmd.pick_clear) begin
            r_pick_i <= r_i3;
            r_pick_d <= r_d3;
            r_pick_x <= r_x3;
            r_pick_y <= r_y3;
        end
    end

    // Current point: the first stored point, then each committed pick
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we && (i_addr == '0)) begin
            r_cur_x <= i_x;
            r_cur_y <= i_y;
        end else if (i_cmd.commit) begin
            r_cur_x <= r_pick_x;
            r_cur_y <= r_pick_y;
        end
    end

    // Running cost
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (i_cmd.total_clear) begin
            r_total <= '0;
        end else if (i_cmd.commit) begin
            r_total <= r_total + TOTAL_W'(r_pick_d);
        end
    end

    assign o_status.pipe_busy  = r_v1 | r_v2 | r_v3;
    assign o_status.pick_found = r_found;
    assign o_total             = r_total;

    // A commit always has a picked point behind it
    a_commit_has_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> r_found)
        else $error("commit without a picked point");

endmodule

### hw/rtl/mmsc_ctrl.sv
// Controller: point loading, sweep sequencing over the store and result strobe.
module mmsc_ctrl
    import mmsc_pkg::*;
#(
    parameter int MAX_POINTS = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic                            i_last_point,
    input  t_dp_status                      i_status,
    output t_dp_cmd                         o_cmd,
    output logic [$clog2(MAX_POINTS)-1:0]   o_addr,
    output logic                            o_busy,
    output logic                            o_done,
    output logic [$clog2(MAX_POINTS+1)-1:0] o_points_used,
    output logic                            o_capacity_exceeded
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    localparam logic [2:0] ST_LOAD   = 3'd0;
    localparam logic [2:0] ST_SWEEP  = 3'd1;
    localparam logic [2:0] ST_DRAIN  = 3'd2;
    localparam logic [2:0] ST_COMMIT = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic [AW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_step, n_step;
    logic          r_first, n_first;
    logic          accept;
    logic          has_room;
    logic [CW-1:0] count_after;

    assign accept      = i_start && (r_state == ST_LOAD);
    assign has_room    = r_count < CW'(MAX_POINTS);
    assign count_after = has_room ? r_count + CW'(1) : r_count;

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_ovf   = r_ovf;
        n_idx   = r_idx;
        n_step  = r_step;
        n_first = r_first;
        o_cmd   = '0;
        o_addr  = r_idx;
        o_cmd.first = r_first;
        unique case (r_state)
            ST_LOAD: begin
                o_addr = r_count[AW-1:0];
                if (accept) begin
                    if (has_room) begin
                        o_cmd.load_we = 1'b1;
                        n_count       = count_after;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last_point) begin
                        o_cmd.total_clear = 1'b1;
                        n_idx   = '0;
                        n_step  = CW'(1);
                        n_first = 1'b1;
                        n_state = (count_after < CW'(2)) ? ST_DONE : ST_SWEEP;
                    end
                end
            end
            ST_SWEEP: begin
                o_cmd.rd_en      = 1'b1;
                o_cmd.pick_clear = (r_idx == '0);
                if (CW'(r_idx) == r_count - CW'(1)) begin
                    n_idx   = '0;
                    n_state = ST_DRAIN;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            ST_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_first      = 1'b0;
                if (r_step == r_count - CW'(1)) begin
                    n_state = ST_DONE;
                end else begin
                    n_step  = r_step + CW'(1);
                    n_state = ST_SWEEP;
                end
            end
            ST_DONE: begin
                n_count = '0;
                n_ovf   = 1'b0;
                n_state = ST_LOAD;
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_idx   <= '0;
            r_step  <= '0;
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_idx   <= n_idx;
            r_step  <= n_step;
            r_first <= n_first;
        end
    end

    assign o_busy              = (r_state != ST_LOAD);
    assign o_done              = (r_state == ST_DONE);
    assign o_points_used       = r_count;
    assign o_capacity_exceeded = r_ovf;

    // Result strobe lasts one cycle and is followed by a return to loading
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done && !o_busy)
        else $error("result strobe longer than one cycle");

    // Fill count never passes the store depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_POINTS))
        else $error("point count beyond store depth");

    // Commit only after the sweep pipeline has emptied
    a_commit_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> !i_status.pipe_busy && !o_cmd.rd_en)
        else $error("commit while sweep in flight");

endmodule

### hw/rtl/manhattan_min_spanning_cost.sv
// Top level of the Manhattan minimum spanning cost block: controller plus datapath.
//
//  Channel   Direction  Ports                                          Transfer
//  --------  ---------  ---------------------------------------------  ----------------------
//  point     in         i_x_coord, i_y_coord, i_last_point             i_start && !o_busy
//  result    out        o_total_cost, o_points_used,                   o_done (one cycle)
//                       o_capacity_exceeded
//
//  Loading takes one cycle per point; o_busy stays low until the final point.
//  With n stored points (n >= 2) the final point holds o_busy high while
//  each Prim step sweeps the point store through its single read port,
//  waits for the sweep pipeline to drain, then commits.
//  A set of one point gives its result in the cycle after the transfer.
//  Reset clears control state, valid bits and the running total only; the stores need no clearing pass.
//  The receiver cannot stall: o_done and the result ports are valid for one cycle.
module manhattan_min_spanning_cost
    import mmsc_pkg::*;
#(
    parameter int MAX_POINTS = 256,
    parameter int COORD_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic signed [COORD_BITS-1:0]    i_x_coord,
    input  logic signed [COORD_BITS-1:0]    i_y_coord,
    input  logic                            i_last_point,
    output logic                            o_done,
    output logic [TOTAL_W-1:0]              o_total_cost,
    output logic [$clog2(MAX_POINTS+1)-1:0] o_points_used,
    output logic                            o_capacity_exceeded
);

    localparam int AW = $clog2(MAX_POINTS);

    t_dp_cmd       cmd;
    t_dp_status    status;
    logic [AW-1:0] addr;

    // Sequencing
    mmsc_ctrl #(
        .MAX_POINTS(MAX_POINTS)
    ) u_ctrl (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_start             (i_start),
        .i_last_point        (i_last_point),
        .i_status            (status),
        .o_cmd               (cmd),
        .o_addr              (addr),
        .o_busy              (o_busy),
        .o_done              (o_done),
        .o_points_used       (o_points_used),
        .o_capacity_exceeded (o_capacity_exceeded)
    );

    // Storage and arithmetic
    mmsc_dp #(
        .MAX_POINTS(MAX_POINTS),
        .COORD_BITS(COORD_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_addr   (addr),
        .i_x      (i_x_coord),
        .i_y      (i_y_coord),
        .o_status (status),
        .o_total  (o_total_cost)
    );

endmodule

### verif/tb_manhattan_min_spanning_cost.sv
// Testbench for manhattan_min_spanning_cost: point sets in, tree cost checked against a Prim walk.
module tb_manhattan_min_spanning_cost;
    import mmsc_pkg::*;

    localparam int MAX_POINTS  = 256;
    localparam int COORD_BITS  = 16;
    localparam int CNT_W       = $clog2(MAX_POINTS + 1);
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_CYCLES = 20;

    // How the coordinates of a random set are spread
    typedef enum int {
        SPREAD_FULL,
        SPREAD_CLUSTER,
        SPREAD_EDGE
    } t_spread;

    typedef struct {
        logic [TOTAL_W-1:0] cost;
        logic [CNT_W-1:0]   used;
        logic               over;
    } t_span_result;

    // Tracks the point set being loaded and the tree costs still to come out
    class span_scoreboard;
        logic signed [COORD_BITS-1:0] pt_x [MAX_POINTS];
        logic signed [COORD_BITS-1:0] pt_y [MAX_POINTS];
        int unsigned  n_stored;
        bit           overflow;
        t_span_result pending [$];
        int           errors;

        function new();
            n_stored = 0;
            overflow = 0;
            errors   = 0;
        endfunction

        task report_mismatch(input string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endtask

        // Dense Prim walk over the stored points; ties go to the lowest index
        function automatic logic [TOTAL_W-1:0] tree_cost();
            int unsigned     best [MAX_POINTS];
            bit              joined [MAX_POINTS];
            longint unsigned total;
            int              cur;
            int              pick;
            int unsigned     pick_d;
            int unsigned     d;
            int              dx;
            int              dy;
            bit              found;
            total = 0;
            if (n_stored < 2) return '0;
            for (int i = 0; i < n_stored; i++) begin
                joined[i] = 1'b0;
                best[i]   = 32'hFFFF_FFFF;
            end
            cur = 0;
            joined[0] = 1'b1;
            for (int step = 1; step < n_stored; step++) begin
                found  = 1'b0;
                pick   = 0;
                pick_d = 32'hFFFF_FFFF;
                for (int i = 0; i < n_stored; i++) begin
                    if (!joined[i]) begin
                        dx = int'(pt_x[cur]) - int'(pt_x[i]);
                        dy = int'(pt_y[cur]) - int'(pt_y[i]);
                        if (dx < 0) dx = -dx;
                        if (dy < 0) dy = -dy;
                        d = dx + dy;
                        if (d < best[i]) best[i] = d;
                        if (!found || best[i] < pick_d) begin
                            pick   = i;
                            pick_d = best[i];
                            found  = 1'b1;
                        end
                    end
                end
                joined[pick] = 1'b1;
                total += pick_d;
                cur = pick;
            end
            return total[TOTAL_W-1:0];
        endfunction

        // One accepted point transfer; the final point closes the set
        task note_point(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
                        input logic last);
            t_span_result res;
            if (n_stored < MAX_POINTS) begin
                pt_x[n_stored] = x;
                pt_y[n_stored] = y;
                n_stored++;
            end else begin
                overflow = 1'b1;
            end
            if (last) begin
                res.cost = tree_cost();
                res.used = n_stored[CNT_W-1:0];
                res.over = overflow;
                pending.insert(pending.size(), res);
                n_stored = 0;
                overflow = 1'b0;
            end
        endtask

        task check_result(input logic [TOTAL_W-1:0] cost, input logic [CNT_W-1:0] used,
                          input logic over);
            t_span_result exp_res;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected result cost=%0d used=%0d", cost, used));
            end else begin
                exp_res = pending.pop_front();
                if (cost !== exp_res.cost)
                    report_mismatch($sformatf("total_cost %0d, want %0d", cost, exp_res.cost));
                if (used !== exp_res.used)
                    report_mismatch($sformatf("points_used %0d, want %0d", used, exp_res.used));
                if (over !== exp_res.over)
                    report_mismatch($sformatf("capacity_exceeded %0b, want %0b",
                                              over, exp_res.over));
            end
        endtask
    endclass

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_start = 1'b0;
    logic                         o_busy;
    logic signed [COORD_BITS-1:0] i_x_coord = '0;
    logic signed [COORD_BITS-1:0] i_y_coord = '0;
    logic                         i_last_point = 1'b0;
    logic                         o_done;
    logic [TOTAL_W-1:0]           o_total_cost;
    logic [CNT_W-1:0]             o_points_used;
    logic                         o_capacity_exceeded;

    span_scoreboard sb = new();
    int unsigned    cycle_count = 0;

    manhattan_min_spanning_cost #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_start             (i_start),
        .o_busy              (o_busy),
        .i_x_coord           (i_x_coord),
        .i_y_coord           (i_y_coord),
        .i_last_point        (i_last_point),
        .o_done              (o_done),
        .o_total_cost        (o_total_cost),
        .o_points_used       (o_points_used),
        .o_capacity_exceeded (o_capacity_exceeded)
    );

    always #5 i_clk = ~i_clk;

    // Result monitor: the strobe is sampled with its pre-edge value
    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            sb.check_result(o_total_cost, o_points_used, o_capacity_exceeded);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // One point transfer, with random idle cycles ahead of it; called right after an edge
    task automatic send_point(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
                              input logic last, input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            i_start      <= 1'b0;
            i_x_coord    <= COORD_BITS'($urandom);
            i_y_coord    <= COORD_BITS'($urandom);
            i_last_point <= 1'($urandom);
            @(posedge i_clk);
        end
        i_start      <= 1'b1;
        i_x_coord    <= x;
        i_y_coord    <= y;
        i_last_point <= last;
        do @(posedge i_clk); while (o_busy);
        sb.note_point(x, y, last);
    endtask

    function automatic logic [COORD_BITS-1:0] pick_coord(input t_spread mode,
                                                        input logic [COORD_BITS-1:0] center);
        logic [COORD_BITS-1:0] v;
        case (mode)
            SPREAD_CLUSTER: v = center + COORD_BITS'($urandom_range(40)) - COORD_BITS'(20);
            SPREAD_EDGE: begin
                case ($urandom_range(4))
                    0:       v = 16'h8000;
                    1:       v = 16'hFFFF;
                    2:       v = 16'h0000;
                    3:       v = 16'h0001;
                    default: v = 16'h7FFF;
                endcase
            end
            default: v = COORD_BITS'($urandom);
        endcase
        return v;
    endfunction

    task automatic send_random_set(input int n_pts, input int idle_pct);
        t_spread               mode;
        t_spread               pt_mode;
        logic [COORD_BITS-1:0] center;
        mode   = t_spread'($urandom_range(2));
        center = COORD_BITS'($urandom);
        for (int i = 0; i < n_pts; i++) begin
            pt_mode = ($urandom_range(7) == 0) ? t_spread'($urandom_range(2)) : mode;
            send_point(pick_coord(pt_mode, center), pick_coord(pt_mode, center),
                       i == n_pts - 1, idle_pct);
        end
    endtask

    // Mostly small sets; an optional oversized set drops points past capacity
    task automatic run_phase(input int idle_pct, input int n_items, input bit with_overflow);
        int sent;
        int n_pts;
        sent = 0;
        if (with_overflow) send_random_set(MAX_POINTS + 2, idle_pct);
        while (sent < n_items) begin
            n_pts = ($urandom_range(9) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
            send_random_set(n_pts, idle_pct);
            sent += n_pts;
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single points: origin and the coordinate extremes
        send_point(16'h0000, 16'h0000, 1'b1, 0);
        send_point(16'h8000, 16'h7FFF, 1'b1, 0);
        // Opposite corners, both diagonals: longest possible edge
        send_point(16'h8000, 16'h8000, 1'b0, 0);
        send_point(16'h7FFF, 16'h7FFF, 1'b1, 0);
        send_point(16'h7FFF, 16'h8000, 1'b0, 0);
        send_point(16'h8000, 16'h7FFF, 1'b1, 0);
        // Coincident points
        send_point(16'h0005, 16'h0005, 1'b0, 0);
        send_point(16'h0005, 16'h0005, 1'b0, 0);
        send_point(16'h0005, 16'h0005, 1'b1, 0);
        // Four corners of the full square
        send_point(16'h8000, 16'h8000, 1'b0, 0);
        send_point(16'h7FFF, 16'h8000, 1'b0, 0);
        send_point(16'h7FFF, 16'h7FFF, 1'b0, 0);
        send_point(16'h8000, 16'h7FFF, 1'b1, 0);
        // Many equal distances: tie breaking in the walk
        send_point(16'h0000, 16'h0000, 1'b0, 0);
        send_point(16'h000A, 16'h0000, 1'b0, 0);
        send_point(16'h0014, 16'h0000, 1'b0, 0);
        send_point(16'h000A, 16'h000A, 1'b0, 0);
        send_point(16'h0000, 16'h000A, 1'b1, 0);
        // Around zero with mixed signs
        send_point(16'hFFFF, 16'hFFFF, 1'b0, 0);
        send_point(16'h0001, 16'h0001, 1'b0, 0);
        send_point(16'hFFFF, 16'h0001, 1'b0, 0);
        send_point(16'h0001, 16'hFFFF, 1'b1, 0);

        // Random sets under different sender gap rates
        run_phase(0, 85, 1'b0);
        run_phase(83, 85, 1'b1);
        run_phase(0, 85, 1'b0);
        run_phase(38, 85, 1'b0);

        i_start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending.size() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending.size()));
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
